### src/wpc_pkg.sv
// Shared constants and status types for the windowed correlation block.
// Used by wpc_sums, wpc_corr and windowed_pearson_correlation.
package wpc_pkg;

    localparam int WINDOW_DEF      = 20;
    localparam int SAMPLE_BITS_DEF = 16;

    // Q1.15 result, quotient of the squared ratio scaled by 2^30, bitwise root
    localparam int CORR_W  = 16;
    localparam int QUO_W   = 31;
    localparam int ROOT_W  = 16;
    localparam int SREM_W  = 20;

    localparam logic [CORR_W-1:0] CORR_MAX_POS = 16'h7FFF;

    typedef struct packed {
        logic done;
        logic has_result;
    } t_sums_stat;

    typedef struct packed {
        logic done;
        logic degenerate;
    } t_corr_stat;

endpackage

### src/wpc_sums.sv
// Sample window memory, running sums and bit-serial moment update.
// Produces the two variance terms and the covariance term; uses wpc_pkg.
module wpc_sums #(
    parameter int WINDOW      = wpc_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_start,
    input  logic                                               i_clear,
    input  logic [SAMPLE_BITS-1:0]                             i_x,
    input  logic [SAMPLE_BITS-1:0]                             i_y,
    output wpc_pkg::t_sums_stat                                o_stat,
    output logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]          o_var_x,
    output logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]          o_var_y,
    output logic [2*(SAMPLE_BITS+$clog2(WINDOW)):0]            o_cov
);
    import wpc_pkg::*;

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + PTR_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + PTR_W;
    localparam int VAR_W  = 2 * SUM_W;
    localparam int COV_W  = VAR_W + 1;
    localparam int CNT_W  = $clog2(SUM_W + 1);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  UPD_LAST  = CNT_W'(SAMPLE_BITS - 1);
    localparam logic [CNT_W-1:0]  MOM_LAST  = CNT_W'(SUM_W - 1);
    localparam logic [VAR_W-1:0]  W_VAR     = VAR_W'(WINDOW);
    localparam logic [COV_W-1:0]  W_COV     = COV_W'(WINDOW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_UPD,
        S_MOM_INIT,
        S_MOM
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [PTR_W-1:0]        r_wp;
    logic [FILL_W-1:0]       r_fill;
    logic                    r_sub;
    logic [SUM_W-1:0]        r_sx, r_sy;
    logic [SQ_W-1:0]         r_sxx, r_syy, r_sxy;
    logic [SAMPLE_BITS-1:0]  r_xmem [WINDOW];
    logic [SAMPLE_BITS-1:0]  r_ymem [WINDOW];
    logic [SAMPLE_BITS-1:0]  r_ox, r_oy;
    logic [SAMPLE_BITS-1:0]  r_xs, r_ys, r_oxs, r_oys;
    logic [SQ_W-1:0]         r_xm, r_ym, r_oxm, r_oym;
    logic [VAR_W-1:0]        r_vx, r_vy;
    logic [COV_W-1:0]        r_cov;
    logic [SUM_W-1:0]        r_mxs, r_mys;
    logic [VAR_W-1:0]        r_mxm, r_mym;
    logic                    r_done, r_has;

    logic [SQ_W-1:0]         n_sxx, n_syy, n_sxy;

    // one bit of each product per cycle: add new term, drop old term
    always_comb begin
        n_sxx = r_sxx + (r_xs[0] ? r_xm : '0) - (r_oxs[0] ? r_oxm : '0);
        n_syy = r_syy + (r_ys[0] ? r_ym : '0) - (r_oys[0] ? r_oym : '0);
        n_sxy = r_sxy + (r_ys[0] ? r_xm : '0) - (r_oys[0] ? r_oxm : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ox          <= r_xmem[r_wp];
            r_oy          <= r_ymem[r_wp];
            r_xmem[r_wp]  <= i_x;
            r_ymem[r_wp]  <= i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_sub   <= 1'b0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
            r_xs    <= '0;
            r_ys    <= '0;
            r_oxs   <= '0;
            r_oys   <= '0;
            r_xm    <= '0;
            r_ym    <= '0;
            r_oxm   <= '0;
            r_oym   <= '0;
            r_vx    <= '0;
            r_vy    <= '0;
            r_cov   <= '0;
            r_mxs   <= '0;
            r_mys   <= '0;
            r_mxm   <= '0;
            r_mym   <= '0;
            r_done  <= 1'b0;
            r_has   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_clear) begin
                        r_wp   <= '0;
                        r_fill <= '0;
                        r_sx   <= '0;
                        r_sy   <= '0;
                        r_sxx  <= '0;
                        r_syy  <= '0;
                        r_sxy  <= '0;
                    end else if (i_start) begin
                        r_xs    <= i_x;
                        r_ys    <= i_y;
                        r_sub   <= (r_fill == FILL_FULL);
                        r_fill  <= (r_fill == FILL_FULL) ? r_fill : r_fill + 1'b1;
                        r_wp    <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // drop the oldest pair only once the window is full
                    r_oxs   <= r_sub ? r_ox : '0;
                    r_oys   <= r_sub ? r_oy : '0;
                    r_oxm   <= r_sub ? SQ_W'(r_ox) : '0;
                    r_oym   <= r_sub ? SQ_W'(r_oy) : '0;
                    r_xm    <= SQ_W'(r_xs);
                    r_ym    <= SQ_W'(r_ys);
                    r_sx    <= r_sx + SUM_W'(r_xs) - (r_sub ? SUM_W'(r_ox) : '0);
                    r_sy    <= r_sy + SUM_W'(r_ys) - (r_sub ? SUM_W'(r_oy) : '0);
                    r_cnt   <= '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sxx <= n_sxx;
                    r_syy <= n_syy;
                    r_sxy <= n_sxy;
                    r_xs  <= r_xs >> 1;
                    r_ys  <= r_ys >> 1;
                    r_oxs <= r_oxs >> 1;
                    r_oys <= r_oys >> 1;
                    r_xm  <= r_xm << 1;
                    r_ym  <= r_ym << 1;
                    r_oxm <= r_oxm << 1;
                    r_oym <= r_oym << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == UPD_LAST) begin
                        if (r_fill == FILL_FULL) begin
                            r_state <= S_MOM_INIT;
                        end else begin
                            r_done  <= 1'b1;
                            r_has   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MOM_INIT: begin
                    r_vx    <= W_VAR * VAR_W'(r_sxx);
                    r_vy    <= W_VAR * VAR_W'(r_syy);
                    r_cov   <= W_COV * COV_W'(r_sxy);
                    r_mxs   <= r_sx;
                    r_mys   <= r_sy;
                    r_mxm   <= VAR_W'(r_sx);
                    r_mym   <= VAR_W'(r_sy);
                    r_cnt   <= '0;
                    r_state <= S_MOM;
                end
                S_MOM: begin
                    r_vx  <= r_vx - (r_mxs[0] ? r_mxm : '0);
                    r_vy  <= r_vy - (r_mys[0] ? r_mym : '0);
                    r_cov <= r_cov - (r_mxs[0] ? COV_W'(r_mym) : '0);
                    r_mxs <= r_mxs >> 1;
                    r_mys <= r_mys >> 1;
                    r_mxm <= r_mxm << 1;
                    r_mym <= r_mym << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MOM_LAST) begin
                        r_done  <= 1'b1;
                        r_has   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat  = '{done: r_done, has_result: r_has};
    assign o_var_x = r_vx;
    assign o_var_y = r_vy;
    assign o_cov   = r_cov;

endmodule

### src/wpc_corr.sv
// Serial products, restoring divide and bitwise square root of the ratio.
// Turns variance and covariance terms into a saturated Q1.15 value; uses wpc_pkg.
module wpc_corr #(
    parameter int WINDOW      = wpc_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]     i_var_x,
    input  logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]     i_var_y,
    input  logic [2*(SAMPLE_BITS+$clog2(WINDOW)):0]       i_cov,
    output wpc_pkg::t_corr_stat                           o_stat,
    output logic [wpc_pkg::CORR_W-1:0]                    o_corr
);
    import wpc_pkg::*;

    localparam int VAR_W    = 2 * (SAMPLE_BITS + $clog2(WINDOW));
    localparam int COV_W    = VAR_W + 1;
    localparam int PROD_W   = 2 * VAR_W;
    localparam int REM_W    = PROD_W + 1;
    localparam int STEP_MAX = (VAR_W > QUO_W) ? VAR_W : QUO_W;
    localparam int CNT_W    = $clog2(STEP_MAX + 1);
    localparam int QS_W     = 2 * ROOT_W;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(VAR_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_DIV,
        C_SQRT
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;
    logic [VAR_W-1:0]     r_pa, r_na;
    logic [PROD_W-1:0]    r_pm, r_nm;
    logic [PROD_W-1:0]    r_p;
    logic [REM_W-1:0]     r_rem;
    logic [QS_W-1:0]      r_qs;
    logic [SREM_W-1:0]    r_sr;
    logic [ROOT_W-1:0]    r_root;
    logic [CORR_W-1:0]    r_corr;
    logic                 r_degen;
    logic                 r_done;

    logic [COV_W-1:0]     n_abs;
    logic                 n_ge;
    logic [REM_W-1:0]     n_diff;
    logic [SREM_W-1:0]    n_srem;
    logic [SREM_W-1:0]    n_trial;
    logic                 n_sge;
    logic [ROOT_W-1:0]    n_root;

    always_comb begin
        n_abs   = i_cov[COV_W-1] ? (~i_cov + 1'b1) : i_cov;
        n_ge    = (r_rem >= REM_W'(r_p));
        n_diff  = n_ge ? (r_rem - REM_W'(r_p)) : r_rem;
        n_srem  = {r_sr[SREM_W-3:0], r_qs[QS_W-1 -: 2]};
        n_trial = SREM_W'({r_root, 2'b01});
        n_sge   = (n_srem >= n_trial);
        n_root  = {r_root[ROOT_W-2:0], n_sge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
            r_pa    <= '0;
            r_na    <= '0;
            r_pm    <= '0;
            r_nm    <= '0;
            r_p     <= '0;
            r_rem   <= '0;
            r_qs    <= '0;
            r_sr    <= '0;
            r_root  <= '0;
            r_corr  <= '0;
            r_degen <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if ((i_var_x == '0) || (i_var_y == '0)) begin
                            r_corr  <= '0;
                            r_degen <= 1'b1;
                            r_done  <= 1'b1;
                        end else begin
                            r_neg   <= i_cov[COV_W-1];
                            r_pa    <= i_var_x;
                            r_pm    <= PROD_W'(i_var_y);
                            r_na    <= n_abs[VAR_W-1:0];
                            r_nm    <= PROD_W'(n_abs[VAR_W-1:0]);
                            r_p     <= '0;
                            r_rem   <= '0;
                            r_qs    <= '0;
                            r_sr    <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= C_MUL;
                        end
                    end
                end
                C_MUL: begin
                    // r_p collects var_x*var_y, r_rem collects cov^2
                    r_p   <= r_p + (r_pa[0] ? r_pm : '0);
                    r_rem <= r_rem + (r_na[0] ? REM_W'(r_nm) : '0);
                    r_pa  <= r_pa >> 1;
                    r_na  <= r_na >> 1;
                    r_pm  <= r_pm << 1;
                    r_nm  <= r_nm << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= C_DIV;
                    end
                end
                C_DIV: begin
                    // quotient of cov^2 * 2^30 over the variance product
                    r_rem <= {n_diff[REM_W-2:0], 1'b0};
                    r_qs  <= {r_qs[QS_W-2:0], n_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= C_SQRT;
                    end
                end
                C_SQRT: begin
                    r_sr   <= n_sge ? (n_srem - n_trial) : n_srem;
                    r_root <= n_root;
                    r_qs   <= r_qs << 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == SQRT_LAST) begin
                        if (r_neg) begin
                            r_corr <= ~n_root + 1'b1;
                        end else begin
                            r_corr <= n_root[ROOT_W-1] ? CORR_MAX_POS : n_root;
                        end
                        r_degen <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_stat = '{done: r_done, degenerate: r_degen};
    assign o_corr = r_corr;

endmodule

### src/windowed_pearson_correlation.sv
// Top level of the sliding-window Pearson correlation block.
// Instantiates wpc_sums and wpc_corr; uses wpc_pkg.
//
//  channel  direction  handshake                 beat fields
//  input    in         i_in_valid / o_in_stall   i_x_sample, i_y_sample, i_last_sample
//  output   out        o_out_valid / i_out_stall o_correlation, o_degenerate
//
// One pair is in flight at a time. A last pair only clears the window; a pair that
// only fills the window goes through the bit-serial square and product update and the
// handoff. A pair that yields a result goes through the update, the serial moments,
// the serial products, 31 divide steps, 16 root steps and the handoff; an output stall
// holding a result keeps the block in its output phase until the register frees up.
// Reset (synchronous, active low) empties the window and zeroes all sums.
// A result waits in the output register while the next pair is taken.
module windowed_pearson_correlation #(
    parameter int WINDOW      = wpc_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = wpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [SAMPLE_BITS-1:0]             i_x_sample,
    input  logic [SAMPLE_BITS-1:0]             i_y_sample,
    input  logic                               i_last_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [wpc_pkg::CORR_W-1:0]  o_correlation,
    output logic                               o_degenerate
);
    import wpc_pkg::*;

    localparam int VAR_W = 2 * (SAMPLE_BITS + $clog2(WINDOW));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUMS,
        ST_CORR,
        ST_PUT
    } t_state;

    t_state               r_state;
    logic                 r_out_valid;
    logic [CORR_W-1:0]    r_corr;
    logic                 r_degen;

    logic                 w_accept;
    logic                 w_corr_start;
    t_sums_stat           s_stat;
    t_corr_stat           c_stat;
    logic [VAR_W-1:0]     w_var_x, w_var_y;
    logic [VAR_W:0]       w_cov;
    logic [CORR_W-1:0]    w_corr;

    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_corr_start = (r_state == ST_SUMS) && s_stat.done && s_stat.has_result;

    wpc_sums #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && !i_last_sample),
        .i_clear (w_accept && i_last_sample),
        .i_x     (i_x_sample),
        .i_y     (i_y_sample),
        .o_stat  (s_stat),
        .o_var_x (w_var_x),
        .o_var_y (w_var_y),
        .o_cov   (w_cov)
    );

    wpc_corr #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_corr_start),
        .i_var_x (w_var_x),
        .i_var_y (w_var_y),
        .i_cov   (w_cov),
        .o_stat  (c_stat),
        .o_corr  (w_corr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_corr      <= '0;
            r_degen     <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && !i_last_sample) begin
                        r_state <= ST_SUMS;
                    end
                end
                ST_SUMS: begin
                    if (s_stat.done) begin
                        r_state <= s_stat.has_result ? ST_CORR : ST_IDLE;
                    end
                end
                ST_CORR: begin
                    if (c_stat.done) begin
                        r_state <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    // hold the result until the output register frees up
                    if (!r_out_valid || !i_out_stall) begin
                        r_corr      <= w_corr;
                        r_degen     <= c_stat.degenerate;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_correlation = r_corr;
    assign o_degenerate  = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> o_correlation == '0)
        else $error("degenerate result with nonzero correlation");

    a_sums_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.done |-> r_state == ST_SUMS)
        else $error("sum update finished outside its phase");

    a_corr_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_stat.done |-> r_state == ST_CORR)
        else $error("correlation unit finished outside its phase");

    a_put_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PUT && !r_out_valid |=> r_out_valid && r_state == ST_IDLE)
        else $error("pending result not moved to output register");

endmodule

### sim/tb_windowed_pearson_correlation.sv
// Testbench for windowed_pearson_correlation: random and directed sample pairs,
// a scoreboard that predicts each windowed correlation with exact integer sums.
// Depends on wpc_pkg and the windowed_pearson_correlation RTL.
module tb_windowed_pearson_correlation;

    localparam int WIN  = 20;
    localparam int SB   = 16;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        logic signed [15:0] corr;
        logic               degen;
    } t_corr_beat;

    class corr_scoreboard;
        logic [15:0] x_hist[WIN];
        logic [15:0] y_hist[WIN];
        int unsigned wr_ptr;
        int unsigned fill;
        logic [63:0] sx, sy, sxx, syy, sxy;
        t_corr_beat  pending[$];
        int          errors;

        function new();
            wr_ptr = 0; fill = 0; errors = 0;
            sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        endfunction

        // Largest m in 0..32768 with m^2*vx*vy <= 2^30*cov^2.
        function automatic logic [15:0] ratio_q15(logic [63:0] vx, logic [63:0] vy,
                                                  logic [63:0] mag);
            logic [191:0] prod, rhs, m2;
            int unsigned lo, hi, mid;
            prod = 192'(vx) * 192'(vy);
            rhs  = (192'(mag) * 192'(mag)) << 30;
            lo = 0; hi = 32768;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                m2 = 192'(mid) * 192'(mid) * prod;
                if (m2 <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return 16'(lo);
        endfunction

        function void note_pair(logic [15:0] x, logic [15:0] y, logic lst);
            logic [63:0] ox, oy, vx, vy, a, b, mag;
            logic [15:0] m;
            t_corr_beat  r;
            if (lst) begin
                wr_ptr = 0; fill = 0;
                sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
                return;
            end
            if (fill >= WIN) begin
                ox = x_hist[wr_ptr]; oy = y_hist[wr_ptr];
                sx -= ox; sy -= oy; sxx -= ox * ox; syy -= oy * oy; sxy -= ox * oy;
            end else begin
                fill++;
            end
            x_hist[wr_ptr] = x; y_hist[wr_ptr] = y;
            sx += x; sy += y;
            sxx += 64'(x) * x; syy += 64'(y) * y; sxy += 64'(x) * y;
            wr_ptr = (wr_ptr + 1) % WIN;
            if (fill < WIN) return;
            vx = WIN * sxx - sx * sx;
            vy = WIN * syy - sy * sy;
            if (vx == 0 || vy == 0) begin
                r.corr = 0; r.degen = 1;
            end else begin
                a = WIN * sxy; b = sx * sy;
                mag = (a < b) ? b - a : a - b;
                m = ratio_q15(vx, vy, mag);
                if (a < b) r.corr = -$signed({1'b0, m});
                else r.corr = (m > 16'h7FFF) ? 16'h7FFF : m;
                r.degen = 0;
            end
            pending.push_back(r);
        endfunction

        function void check_beat(logic signed [15:0] corr, logic degen);
            t_corr_beat e;
            if (pending.size() == 0) begin
                $error("unexpected result beat corr=%0d degenerate=%0b", corr, degen);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (corr !== e.corr) begin
                $error("correlation expected %0d actual %0d", e.corr, corr);
                errors++;
            end
            if (degen !== e.degen) begin
                $error("degenerate expected %0b actual %0b", e.degen, degen);
                errors++;
            end
        endfunction
    endclass

    logic               clk, rst_n;
    logic               in_valid, in_stall, last_s;
    logic [SB-1:0]      x_s, y_s;
    logic               out_valid, out_stall;
    logic signed [15:0] corr;
    logic               degen;
    logic               quiet;
    int                 cycles;
    corr_scoreboard     sb;

    windowed_pearson_correlation DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_x_sample(x_s), .i_y_sample(y_s), .i_last_sample(last_s),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_correlation(corr), .o_degenerate(degen)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Check beats at the rising edge; randomize stall at the falling edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_beat(corr, degen);
    end

    initial begin
        int burst;
        out_stall = 0;
        forever begin
            @(negedge clk);
            if (burst > 0) begin
                burst--;
                out_stall <= 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 4) - 1;
                out_stall <= 1;
            end else begin
                out_stall <= 0;
            end
        end
    end

    task automatic send_pair(logic [15:0] x, logic [15:0] y, logic lst);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 4);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1; x_s <= x; y_s <= y; last_s <= lst;
        do @(posedge clk); while (in_stall);
        sb.note_pair(x, y, lst);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: return 16'($urandom_range(30000, 30010));
            default: return 16'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        logic [15:0] xv, yv;
        int mode, len, kind, sent;
        sb = new();
        quiet = 0;
        rst_n = 0; in_valid = 0; x_s = 0; y_s = 0; last_s = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: constant x (degenerate), then perfect positive, then negative.
        for (int i = 0; i < 21; i++) send_pair(16'hFFFF, 16'(i * 3000), 0);
        send_pair(16'h1234, 16'h4321, 1);
        for (int i = 0; i < 22; i++) send_pair(16'(i * 3000), 16'(i * 3000 + 7), 0);
        send_pair(16'h0000, 16'hFFFF, 1);
        for (int i = 0; i < 22; i++) send_pair(16'(i * 2900), 16'(65535 - i * 2900), 0);
        send_pair(0, 0, 1);
        drain();

        sent = 0;
        while (sent < 1900) begin
            if (sent > 1600) quiet = 1;
            len  = $urandom_range(0, 9) == 0 ? $urandom_range(1, 19)
                                             : $urandom_range(20, 60);
            mode = $urandom_range(0, 3);
            kind = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) begin
                xv = rand_sample(mode);
                case (kind)
                    0: yv = rand_sample(mode);
                    1: yv = xv ^ 16'($urandom_range(0, 3));
                    2: yv = ~xv;
                    default: yv = 16'h0101 * 16'(i % 2);
                endcase
                send_pair(xv, yv, 0);
                sent++;
            end
            send_pair(rand_sample(0), rand_sample(0), 1);
            sent++;
            if ($urandom_range(0, 15) == 0) drain();
        end
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### windowed_pearson_correlation.f
src/wpc_pkg.sv
src/wpc_sums.sv
src/wpc_corr.sv
src/windowed_pearson_correlation.sv
sim/tb_windowed_pearson_correlation.sv
